// ----- rtl/tdrp_pkg.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tdrp_pkg
// Shared types and constants of the typed delimited row parser.
// ---------------------------------------------------------------------------
package tdrp_pkg;

   typedef enum logic [2:0] {
      MODE_LINE     = 3'd0,
      MODE_FIELD    = 3'd1,
      MODE_INT      = 3'd2,
      MODE_DEC_INT  = 3'd3,
      MODE_DEC_FRAC = 3'd4,
      MODE_STR      = 3'd5
   } mode_type;

   typedef enum logic [1:0] {
      PH_IDLE = 2'd0,
      PH_RUN  = 2'd1,
      PH_AUTO = 2'd2
   } phase_type;

   typedef enum logic [2:0] {
      RES_INT      = 3'd0,
      RES_DEC      = 3'd1,
      RES_STR_BYTE = 3'd2,
      RES_STR_END  = 3'd3,
      RES_NULL     = 3'd4,
      RES_ROW_END  = 3'd5,
      RES_ERROR    = 3'd6,
      RES_AUTO_MAX = 3'd7
   } rkind_type;

   localparam logic [1:0] COL_INT  = 2'd0;
   localparam logic [1:0] COL_DEC  = 2'd1;
   localparam logic [1:0] COL_STR  = 2'd2;
   localparam logic [1:0] COL_TIME = 2'd3;

   localparam logic [2:0] CSR_FIELD_DELIM = 3'd0;
   localparam logic [2:0] CSR_ROW_DELIM   = 3'd1;
   localparam logic [2:0] CSR_COL_COUNT   = 3'd2;
   localparam logic [2:0] CSR_COL_KINDS   = 3'd3;
   localparam logic [2:0] CSR_EMPTY_STR   = 3'd4;
   localparam logic [2:0] CSR_AUTO_COL    = 3'd5;

   localparam logic [7:0] CH_BACKSLASH = 8'h5C;
   localparam logic [7:0] CH_MINUS     = 8'h2D;
   localparam logic [7:0] CH_POINT     = 8'h2E;
   localparam logic [7:0] CH_ZERO      = 8'h30;
   localparam logic [7:0] CH_NINE      = 8'h39;
   localparam logic [7:0] CH_N         = 8'h6E;
   localparam logic [7:0] CH_R         = 8'h72;
   localparam logic [7:0] CH_T         = 8'h74;

   localparam logic [63:0] MAG_MAX    = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam logic [63:0] FRAC_LIMIT = (MAG_MAX - 64'd9) / 64'd10;
   localparam logic [4:0]  FRAC_MAX   = 5'd18;
   localparam logic [4:0]  MAX_RESULTS = 5'd20;
   localparam int          QUEUE_DEPTH = 4;

   typedef struct packed {
      rkind_type   kind;
      logic [3:0]  col;
      logic        neg;
      logic [63:0] value;
      logic [4:0]  frac;
      logic [7:0]  chr;
      logic        last;
   } res_cmd_type;

endpackage

// ----- rtl/tdrp_front.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tdrp_front
// Byte parser: holds the registers and parse state, issues one result command
// per cycle into a non-full queue, repeating a byte for short-line fills.
// ---------------------------------------------------------------------------
module tdrp_front
   import tdrp_pkg::*;
#(
   parameter int MAX_COLUMNS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_wdata,
   input  logic        req_valid,
   input  logic [7:0]  req_text_byte,
   input  logic        req_end_of_text,
   output logic        req_stall,
   output logic        q_push,
   output res_cmd_type q_cmd,
   input  logic        q_full
);

   localparam int CW = $clog2(MAX_COLUMNS + 1);

   logic [7:0]  fdel_ff, rdel_ff;
   logic [4:0]  ccount_ff, auto_ff;
   logic [31:0] kinds_ff;
   logic        eas_ff;

   phase_type   phase_ff, phase_in;
   mode_type    mode_ff, mode_in;
   logic [CW-1:0] col_ff, col_in;
   logic        esc_ff, esc_in, neg_ff, neg_in, dig_ff, dig_in, err_ff, err_in;
   logic [63:0] acc_ff, acc_in;
   logic [4:0]  frac_ff, frac_in;
   logic [31:0] amax_ff, amax_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic [7:0]  c_ff;
   logic        eof_ff;

   logic [7:0]  cur_c;
   logic        cur_eof, active, push, fin, to_auto;
   logic        fs, fv, fl, rs, fd, rd, is_digit, esc_ok;
   logic [3:0]  d;
   logic [7:0]  esc_c;
   logic [5:0]  col6, n6, auto6;
   logic [CW-1:0] col_next;
   logic [1:0]  ck;
   logic [3:0]  col_err4;
   logic [31:0] int_next, int_val;
   logic [67:0] dec_next;
   res_cmd_type cmd;

   assign cur_c   = (phase_ff == PH_IDLE) ? req_text_byte : c_ff;
   assign cur_eof = (phase_ff == PH_IDLE) ? req_end_of_text : eof_ff;
   assign active  = ((phase_ff != PH_IDLE) || req_valid) && !q_full;
   assign req_stall = (phase_ff != PH_IDLE) || q_full;

   assign col6  = 6'(col_ff);
   assign auto6 = {1'b0, auto_ff};

   always_comb begin
      if (ccount_ff == 5'd0) begin
         n6 = 6'd1;
      end else if ({1'b0, ccount_ff} > 6'(MAX_COLUMNS)) begin
         n6 = 6'(MAX_COLUMNS);
      end else begin
         n6 = {1'b0, ccount_ff};
      end
   end

   // columns beyond the kinds register parse as integers
   assign ck       = (col6 >= 6'd16) ? COL_INT : kinds_ff[{col6[3:0], 1'b0} +: 2];
   assign col_err4 = (col6 > 6'd15) ? 4'hF : col6[3:0];
   assign col_next = (col6 < 6'(MAX_COLUMNS)) ? CW'(col6 + 6'd1) : col_ff;

   assign fd       = !cur_eof && (cur_c == fdel_ff);
   assign rd       = cur_eof || (cur_c == rdel_ff);
   assign is_digit = !cur_eof && (cur_c >= CH_ZERO) && (cur_c <= CH_NINE);
   assign d        = is_digit ? 4'(cur_c - CH_ZERO) : 4'd0;

   assign int_next = {acc_ff[28:0], 3'b000} + {acc_ff[30:0], 1'b0} + 32'(d);
   assign int_val  = neg_ff ? (32'd0 - acc_ff[31:0]) : acc_ff[31:0];
   assign dec_next = {1'b0, acc_ff, 3'b000} + {3'b000, acc_ff, 1'b0} + 68'(d);

   always_comb begin
      esc_ok = 1'b1;
      priority if (cur_c == CH_N) begin
         esc_c = 8'd10;
      end else if (cur_c == CH_R) begin
         esc_c = 8'd13;
      end else if (cur_c == CH_T) begin
         esc_c = 8'd9;
      end else if (cur_c == CH_BACKSLASH) begin
         esc_c = CH_BACKSLASH;
      end else if (cur_c == CH_ZERO) begin
         esc_c = 8'd0;
      end else begin
         esc_c  = cur_c;
         esc_ok = (cur_c == fdel_ff);
      end
   end

   // one parse step: at most one result command
   always_comb begin
      mode_in = mode_ff;
      col_in  = col_ff;
      esc_in  = esc_ff;
      neg_in  = neg_ff;
      dig_in  = dig_ff;
      err_in  = err_ff;
      acc_in  = acc_ff;
      frac_in = frac_ff;
      amax_in = amax_ff;
      push    = 1'b0;
      cmd     = '0;
      fin     = 1'b1;
      to_auto = 1'b0;
      fs      = 1'b0;
      fv      = 1'b0;
      fl      = 1'b0;
      rs      = 1'b0;

      if (phase_ff == PH_AUTO) begin
         push      = 1'b1;
         cmd.kind  = RES_AUTO_MAX;
         cmd.col   = auto_ff[3:0];
         cmd.value = {32'd0, amax_ff};
         rs        = 1'b1;
      end else if (err_ff) begin
         rs = cur_eof;
      end else begin
         unique case (mode_ff)
            MODE_LINE: begin
               if (cur_eof) begin
                  if (auto6 < n6) begin
                     push      = 1'b1;
                     cmd.kind  = RES_AUTO_MAX;
                     cmd.col   = auto_ff[3:0];
                     cmd.value = {32'd0, amax_ff};
                  end
                  rs = 1'b1;
               end else if (cur_c != rdel_ff) begin
                  mode_in = MODE_FIELD;
                  fs      = 1'b1;
               end
            end
            MODE_FIELD: fs = 1'b1;
            MODE_INT: begin
               if (is_digit) begin
                  dig_in = 1'b1;
                  acc_in = {32'd0, int_next};
               end else if (!dig_ff) begin
                  fl = 1'b1;
               end else begin
                  fv = 1'b1;
               end
            end
            MODE_DEC_INT: begin
               if (is_digit) begin
                  dig_in = 1'b1;
                  acc_in = (dec_next > {4'd0, MAG_MAX}) ? MAG_MAX : dec_next[63:0];
               end else if (!dig_ff) begin
                  fl = 1'b1;
               end else if (!cur_eof && (cur_c == CH_POINT)) begin
                  mode_in = MODE_DEC_FRAC;
               end else begin
                  fv = 1'b1;
               end
            end
            MODE_DEC_FRAC: begin
               if (is_digit) begin
                  if ((frac_ff < FRAC_MAX) && (acc_ff <= FRAC_LIMIT)) begin
                     acc_in  = dec_next[63:0];
                     frac_in = frac_ff + 5'd1;
                  end
               end else begin
                  fv = 1'b1;
               end
            end
            MODE_STR: begin
               if (esc_ff) begin
                  esc_in = 1'b0;
                  if (cur_eof || !esc_ok) begin
                     fl = 1'b1;
                  end else begin
                     push     = 1'b1;
                     cmd.kind = RES_STR_BYTE;
                     cmd.col  = col6[3:0];
                     cmd.chr  = esc_c;
                  end
               end else if (fd || rd) begin
                  fv = 1'b1;
               end else if (cur_c == CH_BACKSLASH) begin
                  esc_in = 1'b1;
               end else begin
                  push     = 1'b1;
                  cmd.kind = RES_STR_BYTE;
                  cmd.col  = col6[3:0];
                  cmd.chr  = cur_c;
               end
            end
            default: rs = 1'b1;
         endcase
      end

      // value ended
      if (fv) begin
         if (!fd && !rd) begin
            fl = 1'b1;
         end else begin
            push    = 1'b1;
            cmd.col = col6[3:0];
            if (mode_ff == MODE_INT) begin
               cmd.kind  = RES_INT;
               cmd.value = {32'd0, acc_ff[31:0]};
               cmd.neg   = neg_ff;
               if ((col6 == auto6) && ($signed(int_val) > $signed(amax_ff))) begin
                  amax_in = int_val;
               end
            end else if (mode_ff == MODE_STR) begin
               cmd.kind = RES_STR_END;
            end else begin
               cmd.kind  = RES_DEC;
               cmd.value = acc_ff;
               cmd.neg   = neg_ff;
               cmd.frac  = frac_ff;
            end
            col_in  = col_next;
            mode_in = MODE_FIELD;
            fin     = !rd;
         end
      end

      // start of a field, or one step of a short-line fill
      if (fs) begin
         if (col6 >= n6) begin
            if (rd) begin
               push     = 1'b1;
               cmd.kind = RES_ROW_END;
               mode_in  = MODE_LINE;
               col_in   = '0;
               if (cur_eof) begin
                  if (auto6 < n6) begin
                     fin     = 1'b0;
                     to_auto = 1'b1;
                  end else begin
                     rs = 1'b1;
                  end
               end
            end else begin
               fl = 1'b1;
            end
         end else if (fd || (rd && (col6 == n6 - 6'd1))) begin
            push     = 1'b1;
            cmd.kind = ((ck == COL_STR) && eas_ff) ? RES_STR_END : RES_NULL;
            cmd.col  = col6[3:0];
            col_in   = col_next;
            mode_in  = MODE_FIELD;
            fin      = fd;
         end else if (rd) begin
            if (ck == COL_STR) begin
               push     = 1'b1;
               cmd.kind = RES_STR_END;
               cmd.col  = col6[3:0];
               col_in   = col_next;
               fin      = 1'b0;
            end else begin
               fl = 1'b1;
            end
         end else begin
            acc_in  = '0;
            frac_in = '0;
            neg_in  = 1'b0;
            dig_in  = 1'b0;
            esc_in  = 1'b0;
            if (ck == COL_STR) begin
               mode_in = MODE_STR;
               if (cur_c == CH_BACKSLASH) begin
                  esc_in = 1'b1;
               end else begin
                  push     = 1'b1;
                  cmd.kind = RES_STR_BYTE;
                  cmd.col  = col6[3:0];
                  cmd.chr  = cur_c;
               end
            end else begin
               mode_in = (ck == COL_DEC) ? MODE_DEC_INT : MODE_INT;
               if (cur_c == CH_MINUS) begin
                  neg_in = 1'b1;
               end else if (!is_digit) begin
                  fl = 1'b1;
               end else begin
                  dig_in = 1'b1;
                  acc_in = {60'd0, d};
               end
            end
         end
      end

      if (fl) begin
         push     = 1'b1;
         cmd      = '0;
         cmd.kind = RES_ERROR;
         cmd.col  = col_err4;
         err_in   = 1'b1;
         fin      = 1'b1;
         to_auto  = 1'b0;
      end

      if (rs) begin
         mode_in = MODE_LINE;
         col_in  = '0;
         esc_in  = 1'b0;
         neg_in  = 1'b0;
         dig_in  = 1'b0;
         err_in  = 1'b0;
         acc_in  = '0;
         frac_in = '0;
         amax_in = '0;
      end

      cmd.last = fin || (cnt_ff == MAX_RESULTS - 5'd1);
   end

   always_comb begin
      if (!active) begin
         phase_in = phase_ff;
      end else if (fin) begin
         phase_in = PH_IDLE;
      end else if (to_auto) begin
         phase_in = PH_AUTO;
      end else begin
         phase_in = PH_RUN;
      end
   end

   always_comb begin
      cnt_in = cnt_ff;
      if (active) begin
         if (fin) begin
            cnt_in = '0;
         end else if (push && (cnt_ff < MAX_RESULTS)) begin
            cnt_in = cnt_ff + 5'd1;
         end
      end
   end

   // results past the run limit are dropped
   assign q_push = active && push && (cnt_ff < MAX_RESULTS);
   assign q_cmd  = cmd;

   always_ff @(posedge clock) begin
      if (reset) begin
         fdel_ff   <= 8'd58;
         rdel_ff   <= 8'd10;
         ccount_ff <= 5'd1;
         kinds_ff  <= '0;
         eas_ff    <= 1'b0;
         auto_ff   <= 5'd16;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_FIELD_DELIM: fdel_ff   <= csr_wdata[7:0];
            CSR_ROW_DELIM:   rdel_ff   <= csr_wdata[7:0];
            CSR_COL_COUNT:   ccount_ff <= csr_wdata[4:0];
            CSR_COL_KINDS:   kinds_ff  <= csr_wdata;
            CSR_EMPTY_STR:   eas_ff    <= csr_wdata[0];
            CSR_AUTO_COL:    auto_ff   <= csr_wdata[4:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         mode_ff  <= MODE_LINE;
         col_ff   <= '0;
         esc_ff   <= 1'b0;
         neg_ff   <= 1'b0;
         dig_ff   <= 1'b0;
         err_ff   <= 1'b0;
         acc_ff   <= '0;
         frac_ff  <= '0;
         amax_ff  <= '0;
         cnt_ff   <= '0;
      end else begin
         phase_ff <= phase_in;
         cnt_ff   <= cnt_in;
         if (active) begin
            mode_ff <= mode_in;
            col_ff  <= col_in;
            esc_ff  <= esc_in;
            neg_ff  <= neg_in;
            dig_ff  <= dig_in;
            err_ff  <= err_in;
            acc_ff  <= acc_in;
            frac_ff <= frac_in;
            amax_ff <= amax_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (active && (phase_ff == PH_IDLE)) begin
         c_ff   <= req_text_byte;
         eof_ff <= req_end_of_text;
      end
   end

endmodule

// ----- rtl/tdrp_queue.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tdrp_queue
// Short first-in first-out queue of result commands between the parser and
// the output stage.
// ---------------------------------------------------------------------------
module tdrp_queue
   import tdrp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   input  res_cmd_type din,
   input  logic        pop,
   output res_cmd_type dout,
   output logic        empty,
   output logic        full
);

   localparam int AW = $clog2(QUEUE_DEPTH);

   res_cmd_type          mem_ff [QUEUE_DEPTH];
   logic [AW-1:0]        wr_ff, wr_in, rd_ff, rd_in;
   logic [AW:0]          cnt_ff, cnt_in;

   assign empty = (cnt_ff == '0);
   assign full  = (cnt_ff == (AW + 1)'(QUEUE_DEPTH));
   assign dout  = mem_ff[rd_ff];

   always_comb begin
      wr_in  = push ? wr_ff + 1'b1 : wr_ff;
      rd_in  = pop ? rd_ff + 1'b1 : rd_ff;
      cnt_in = cnt_ff + (AW + 1)'(push) - (AW + 1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= din;
      end
   end

endmodule

// ----- rtl/tdrp_back.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tdrp_back
// Output stage: takes result commands off the queue, applies sign and
// extension to the numbers and holds the result word for the consumer.
// ---------------------------------------------------------------------------
module tdrp_back
   import tdrp_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               q_empty,
   input  res_cmd_type        q_dout,
   output logic               q_pop,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [2:0]         rsp_result_kind,
   output logic [3:0]         rsp_column_index,
   output logic signed [63:0] rsp_number_value,
   output logic [4:0]         rsp_fraction_digits,
   output logic [7:0]         rsp_string_byte,
   output logic               rsp_last_of_run
);

   logic        valid_ff;
   logic [2:0]  kind_ff;
   logic [3:0]  col_ff;
   logic [63:0] num_ff, num_in;
   logic [4:0]  frac_ff, frac_in;
   logic [7:0]  chr_ff, chr_in;
   logic        last_ff;
   logic [31:0] v32;

   assign q_pop = !q_empty && (!valid_ff || !rsp_stall);
   assign v32   = q_dout.neg ? (32'd0 - q_dout.value[31:0]) : q_dout.value[31:0];

   always_comb begin
      num_in  = '0;
      frac_in = '0;
      chr_in  = '0;
      unique case (q_dout.kind)
         RES_INT:      num_in = {{32{v32[31]}}, v32};
         RES_DEC: begin
            num_in  = q_dout.neg ? (64'd0 - q_dout.value) : q_dout.value;
            frac_in = q_dout.frac;
         end
         RES_STR_BYTE: chr_in = q_dout.chr;
         RES_AUTO_MAX: num_in = {{32{q_dout.value[31]}}, q_dout.value[31:0]};
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (q_pop) begin
         valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         kind_ff <= q_dout.kind;
         col_ff  <= q_dout.col;
         num_ff  <= num_in;
         frac_ff <= frac_in;
         chr_ff  <= chr_in;
         last_ff <= q_dout.last;
      end
   end

   assign rsp_valid           = valid_ff;
   assign rsp_result_kind     = kind_ff;
   assign rsp_column_index    = col_ff;
   assign rsp_number_value    = $signed(num_ff);
   assign rsp_fraction_digits = frac_ff;
   assign rsp_string_byte     = chr_ff;
   assign rsp_last_of_run     = last_ff;

endmodule

// ----- rtl/typed_delimited_row_parser.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// typed_delimited_row_parser
// Parses delimited text into typed column results, one byte per word.
//
// channel  | ports  | moves
// ---------+--------+------------------------------------------------------
// request  | req_*  | one text byte or end-of-file mark per word
// response | rsp_*  | one parse result per word, last_of_run on the final one
// config   | csr_*  | register writes: user waits for parser idle; unchecked
//
// A byte yields its results one per cycle. Short-line fills, the row end
// and the auto maximum at end of file come out one per cycle while the
// byte is held and the input stalls. The parser also stalls on a full
// four-entry result queue; the output register lets the consumer stall
// without stopping the parser until the queue fills.
// Synchronous reset returns parse state and registers to their defaults.
// ---------------------------------------------------------------------------
module typed_delimited_row_parser
   import tdrp_pkg::*;
#(
   parameter int MAX_COLUMNS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_we,
   input  logic [2:0]         csr_index,
   input  logic [31:0]        csr_wdata,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [7:0]         req_text_byte,
   input  logic               req_end_of_text,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [2:0]         rsp_result_kind,
   output logic [3:0]         rsp_column_index,
   output logic signed [63:0] rsp_number_value,
   output logic [4:0]         rsp_fraction_digits,
   output logic [7:0]         rsp_string_byte,
   output logic               rsp_last_of_run
);

   logic        q_push, q_pop, q_empty, q_full;
   res_cmd_type q_din, q_dout;

   tdrp_front #(
      .MAX_COLUMNS(MAX_COLUMNS)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .req_valid      (req_valid),
      .req_text_byte  (req_text_byte),
      .req_end_of_text(req_end_of_text),
      .req_stall      (req_stall),
      .q_push         (q_push),
      .q_cmd          (q_din),
      .q_full         (q_full)
   );

   tdrp_queue u_queue (
      .clock(clock),
      .reset(reset),
      .push (q_push),
      .din  (q_din),
      .pop  (q_pop),
      .dout (q_dout),
      .empty(q_empty),
      .full (q_full)
   );

   tdrp_back u_back (
      .clock              (clock),
      .reset              (reset),
      .q_empty            (q_empty),
      .q_dout             (q_dout),
      .q_pop              (q_pop),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_result_kind    (rsp_result_kind),
      .rsp_column_index   (rsp_column_index),
      .rsp_number_value   (rsp_number_value),
      .rsp_fraction_digits(rsp_fraction_digits),
      .rsp_string_byte    (rsp_string_byte),
      .rsp_last_of_run    (rsp_last_of_run)
   );

endmodule

// ----- bench/tb_typed_delimited_row_parser.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_typed_delimited_row_parser
// Self-checking bench for the typed delimited row parser. Text words go in
// with random gaps, and a behavioral parser in the bench predicts every
// result. Results come out under random stalls and are compared field by
// field in order. Directed tests cover types, escapes, short lines, errors
// and register extremes. A random part follows: mostly well-formed rows
// under random layouts, plus noise.
// ---------------------------------------------------------------------------
module tb_typed_delimited_row_parser;
   import tdrp_pkg::*;

   typedef struct {
      rkind_type   kind;
      logic [3:0]  col;
      logic [63:0] num;
      logic [4:0]  frac;
      logic [7:0]  chr;
      logic        last;
   } parse_result_t;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               csr_we = 1'b0;
   logic [2:0]         csr_index = '0;
   logic [31:0]        csr_wdata = '0;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic [7:0]         req_text_byte = '0;
   logic               req_end_of_text = 1'b0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b1;
   logic [2:0]         rsp_result_kind;
   logic [3:0]         rsp_column_index;
   logic signed [63:0] rsp_number_value;
   logic [4:0]         rsp_fraction_digits;
   logic [7:0]         rsp_string_byte;
   logic               rsp_last_of_run;

   typed_delimited_row_parser dut (.*);

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   initial begin
      #3_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

   // register copies
   logic [7:0]  fdel, rdel;
   logic [4:0]  ccount, acol;
   logic [31:0] ckinds;
   logic        eas;
   // parser state copies
   mode_type    mode;
   logic [4:0]  cur_col, fcnt;
   logic        esc, neg, dig, errh;
   logic [63:0] acc;
   logic [31:0] amax;

   parse_result_t step_results[$];
   parse_result_t pending_results[$];
   int  errors = 0;
   int  words_sent = 0;
   bit  tx_quiet = 0;
   bit  rx_quiet = 0;
   logic long_hold_on = 1'b0;

   function automatic void add_result(rkind_type k, logic [4:0] col, logic [63:0] num,
                                      logic [4:0] frac, logic [7:0] ch);
      parse_result_t r;
      if (step_results.size() >= MAX_RESULTS) return;
      r.kind = k; r.col = col[3:0]; r.num = num; r.frac = frac; r.chr = ch; r.last = 1'b0;
      step_results.push_back(r);
   endfunction

   function automatic logic [4:0] eff_count();
      if (ccount < 1) return 5'd1;
      if (ccount > 16) return 5'd16;
      return ccount;
   endfunction

   function automatic logic [1:0] kind_at(logic [4:0] col);
      if (col >= 16) return COL_INT;
      return ckinds[2*col +: 2];
   endfunction

   function automatic void parser_restart();
      mode = MODE_LINE; cur_col = 0; esc = 0; neg = 0; dig = 0; errh = 0;
      acc = 0; fcnt = 0; amax = 0;
   endfunction

   function automatic void raise_error();
      add_result(RES_ERROR, (cur_col > 15) ? 5'd15 : cur_col, 0, 0, 0);
      errh = 1;
   endfunction

   function automatic void close_file();
      if (acol < eff_count())
         add_result(RES_AUTO_MAX, acol, {{32{amax[31]}}, amax}, 0, 0);
      parser_restart();
   endfunction

   function automatic void bump_column();
      if (cur_col < 16) cur_col++;
   endfunction

   function automatic void field_start(logic [7:0] c, logic eof);
      logic [4:0] n;
      logic fd, rd;
      logic [1:0] k;
      forever begin
         n = eff_count();
         fd = !eof && c == fdel;
         rd = eof || c == rdel;
         if (cur_col >= n) begin
            if (rd) begin
               add_result(RES_ROW_END, 0, 0, 0, 0);
               mode = MODE_LINE; cur_col = 0;
               if (eof) close_file();
               return;
            end
            raise_error();
            return;
         end
         k = kind_at(cur_col);
         if (fd || (rd && cur_col == n - 1)) begin
            if (k == COL_STR && eas) add_result(RES_STR_END, cur_col, 0, 0, 0);
            else add_result(RES_NULL, cur_col, 0, 0, 0);
            bump_column();
            if (fd) begin
               mode = MODE_FIELD;
               return;
            end
            continue;
         end
         if (rd) begin
            if (k == COL_STR) begin
               add_result(RES_STR_END, cur_col, 0, 0, 0);
               bump_column();
               continue;
            end
            raise_error();
            return;
         end
         acc = 0; fcnt = 0; neg = 0; dig = 0; esc = 0;
         if (k == COL_STR) begin
            mode = MODE_STR;
            if (c == CH_BACKSLASH) esc = 1;
            else add_result(RES_STR_BYTE, cur_col, 0, 0, c);
            return;
         end
         mode = (k == COL_DEC) ? MODE_DEC_INT : MODE_INT;
         if (c == CH_MINUS) begin
            neg = 1;
            return;
         end
         if (c < CH_ZERO || c > CH_NINE) begin
            raise_error();
            return;
         end
         dig = 1;
         acc = 64'(c - CH_ZERO);
         return;
      end
   endfunction

   function automatic void value_done(logic [7:0] c, logic eof);
      logic fd, rd;
      logic [31:0] v;
      logic [63:0] m;
      fd = !eof && c == fdel;
      rd = eof || c == rdel;
      if (!fd && !rd) begin
         raise_error();
         return;
      end
      if (mode == MODE_INT) begin
         v = acc[31:0];
         if (neg) v = -v;
         add_result(RES_INT, cur_col, {{32{v[31]}}, v}, 0, 0);
         if (cur_col == acol && $signed(v) > $signed(amax)) amax = v;
      end else if (mode == MODE_STR) begin
         add_result(RES_STR_END, cur_col, 0, 0, 0);
      end else begin
         m = neg ? -acc : acc;
         add_result(RES_DEC, cur_col, m, fcnt, 0);
      end
      bump_column();
      mode = MODE_FIELD;
      if (rd) field_start(c, eof);
   endfunction

   function automatic void string_char(logic [7:0] c, logic eof);
      if (esc) begin
         esc = 0;
         if (eof) begin
            raise_error();
            return;
         end
         if (c == CH_N) c = 8'd10;
         else if (c == CH_R) c = 8'd13;
         else if (c == CH_T) c = 8'd9;
         else if (c == CH_ZERO) c = 8'd0;
         else if (c != CH_BACKSLASH && c != fdel) begin
            raise_error();
            return;
         end
         add_result(RES_STR_BYTE, cur_col, 0, 0, c);
         return;
      end
      if (eof || c == fdel || c == rdel) begin
         value_done(c, eof);
         return;
      end
      if (c == CH_BACKSLASH) esc = 1;
      else add_result(RES_STR_BYTE, cur_col, 0, 0, c);
   endfunction

   // expected results of one accepted word
   function automatic void predict_word(logic [7:0] c, logic eof);
      logic is_digit;
      logic [63:0] d;
      parse_result_t r;
      is_digit = !eof && c >= CH_ZERO && c <= CH_NINE;
      d = is_digit ? 64'(c - CH_ZERO) : 64'd0;
      step_results.delete();
      if (errh) begin
         if (eof) parser_restart();
      end else begin
         case (mode)
            MODE_LINE: begin
               if (eof) close_file();
               else if (c != rdel) begin
                  cur_col = 0;
                  mode = MODE_FIELD;
                  field_start(c, 1'b0);
               end
            end
            MODE_FIELD: field_start(c, eof);
            MODE_INT: begin
               if (is_digit) begin
                  dig = 1;
                  acc = (acc * 10 + d) & 64'hFFFF_FFFF;
               end else if (!dig) raise_error();
               else value_done(c, eof);
            end
            MODE_DEC_INT: begin
               if (is_digit) begin
                  dig = 1;
                  if (acc > (MAG_MAX - d) / 10) acc = MAG_MAX;
                  else acc = acc * 10 + d;
               end else if (!dig) raise_error();
               else if (!eof && c == CH_POINT) mode = MODE_DEC_FRAC;
               else value_done(c, eof);
            end
            MODE_DEC_FRAC: begin
               if (is_digit) begin
                  if (fcnt < FRAC_MAX && acc <= FRAC_LIMIT) begin
                     acc = acc * 10 + d;
                     fcnt++;
                  end
               end else value_done(c, eof);
            end
            MODE_STR: string_char(c, eof);
            default: parser_restart();
         endcase
      end
      foreach (step_results[i]) begin
         r = step_results[i];
         r.last = (i == step_results.size() - 1);
         pending_results.push_back(r);
      end
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // result side: random stalls and in-order compare
   int  stall_left = 0;
   bit  hold_taken = 0;
   always @(posedge clock) begin
      parse_result_t want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_results.size() == 0) begin
            if (errors < 10)
               $display("unexpected result kind %0d col %0d", rsp_result_kind,
                        rsp_column_index);
            errors++;
         end else begin
            want = pending_results.pop_front();
            if (rsp_result_kind !== want.kind || rsp_column_index !== want.col ||
                rsp_number_value !== want.num || rsp_fraction_digits !== want.frac ||
                rsp_string_byte !== want.chr || rsp_last_of_run !== want.last) begin
               if (errors < 10)
                  $display("exp %0d %0d %0d %0d %h %0d got %0d %0d %0d %0d %h %0d",
                     want.kind, want.col, $signed(want.num), want.frac, want.chr, want.last,
                     rsp_result_kind, rsp_column_index, rsp_number_value,
                     rsp_fraction_digits, rsp_string_byte, rsp_last_of_run);
               errors++;
            end
         end
      end
      if (long_hold_on && !hold_taken) begin
         stall_left = 400;
         hold_taken = 1;
      end
      if (stall_left > 0) begin
         rsp_stall <= 1'b1;
         stall_left--;
      end else if (!rx_quiet && $urandom_range(0, 99) < 25) begin
         stall_left = pick_gap();
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   task automatic send_word(logic [7:0] c, logic eof);
      int gap;
      req_valid <= 1'b1;
      req_text_byte <= c;
      req_end_of_text <= eof;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_word(c, eof);
      words_sent++;
      gap = tx_quiet ? 0 : pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic send_text(string s);
      for (int i = 0; i < s.len(); i++) send_word(s[i], 1'b0);
   endtask

   task automatic send_eof();
      send_word(8'($urandom_range(0, 255)), 1'b1);
   endtask

   // waits out all pending results, then a margin for result-free words
   task automatic drain();
      int guard;
      guard = 0;
      req_valid <= 1'b0;
      while (pending_results.size() > 0 && guard < 200000) begin
         @(posedge clock);
         guard++;
      end
      repeat (60) @(posedge clock);
   endtask

   task automatic set_reg(logic [2:0] idx, logic [31:0] val);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
      case (idx)
         CSR_FIELD_DELIM: fdel = val[7:0];
         CSR_ROW_DELIM:   rdel = val[7:0];
         CSR_COL_COUNT:   ccount = val[4:0];
         CSR_COL_KINDS:   ckinds = val;
         CSR_EMPTY_STR:   eas = val[0];
         CSR_AUTO_COL:    acol = val[4:0];
         default: ;
      endcase
   endtask

   task automatic set_layout(logic [7:0] fd, logic [7:0] rd, logic [4:0] n,
                             logic [31:0] kinds, logic es, logic [4:0] ac);
      set_reg(CSR_FIELD_DELIM, {24'd0, fd});
      set_reg(CSR_ROW_DELIM, {24'd0, rd});
      set_reg(CSR_COL_COUNT, {27'd0, n});
      set_reg(CSR_COL_KINDS, kinds);
      set_reg(CSR_EMPTY_STR, {31'd0, es});
      set_reg(CSR_AUTO_COL, {27'd0, ac});
   endtask

   task automatic test_defaults();
      send_text("123\n\n-5\n");
      send_text("x");
      send_text("9\n");
      send_eof();
      send_text("7");
      send_eof();
      drain();
   endtask

   // columns: int, decimal, string, time; auto on the time column
   task automatic test_column_types();
      set_layout(":", "\n", 4, {24'd0, COL_TIME, COL_STR, COL_DEC, COL_INT}, 1'b0, 3);
      send_text("-2147483648:3.14:a\\nb\\:c\\r\\t\\\\\\0:99\n");
      send_text("99999999999:-0.5::-7:\n");
      send_text("1:99999999999999999999.1234567890123456789:z\n");
      send_eof();
      drain();
      send_text("1:2.\n");
      send_text("-:");
      send_eof();
      send_text("1:-.\n");
      send_eof();
      send_text("1:2:s\\q");
      send_eof();
      send_text("1:2:s\\");
      send_eof();
      send_text("1:2:s:3:4\n");
      send_eof();
      send_text("5:0.000000000000000000001:");
      send_eof();
      drain();
   endtask

   task automatic test_register_extremes();
      set_layout(8'h00, 8'hFF, 16, 32'hAAAA_AAAA, 1'b1, 0);
      send_text("ab");
      send_word(8'hFF, 1'b0);
      send_word(8'h00, 1'b0);
      send_word(8'hFF, 1'b0);
      send_eof();
      drain();
      set_layout(8'hFF, 8'h00, 0, 32'hFFFF_FFFF, 1'b0, 31);
      send_text("42");
      send_word(8'h00, 1'b0);
      send_eof();
      drain();
      set_layout(":", "\n", 31, 32'h0000_0002, 1'b0, 16);
      send_text("s:1\n");
      send_eof();
      drain();
   endtask

   task automatic test_full_queue();
      tx_quiet = 1;
      set_layout(",", "\n", 2, {28'd0, COL_STR, COL_STR}, 1'b1, 16);
      long_hold_on <= 1'b1;
      for (int i = 0; i < 60; i++) send_word(8'($urandom_range(8'h61, 8'h7A)), 1'b0);
      send_text(",\n");
      long_hold_on <= 1'b0;
      tx_quiet = 0;
      drain();
   endtask

   function automatic logic [7:0] pick_delim(bit row);
      int r;
      r = $urandom_range(0, 9);
      if (r < 2) return 8'($urandom_range(0, 255));
      if (row) return (r < 7) ? 8'h0A : 8'h3B;
      case (r % 4)
         0: return 8'h3A;
         1: return 8'h2C;
         2: return 8'h09;
         default: return 8'h7C;
      endcase
   endfunction

   task automatic send_random_field(logic [1:0] k);
      int len;
      if ($urandom_range(0, 9) == 0) return;
      if (k == COL_STR) begin
         len = $urandom_range(1, 6);
         repeat (len) begin
            case ($urandom_range(0, 5))
               0: begin
                  send_word(CH_BACKSLASH, 1'b0);
                  case ($urandom_range(0, 6))
                     0: send_word(CH_N, 1'b0);
                     1: send_word(CH_R, 1'b0);
                     2: send_word(CH_T, 1'b0);
                     3: send_word(CH_ZERO, 1'b0);
                     4: send_word(CH_BACKSLASH, 1'b0);
                     5: send_word(fdel, 1'b0);
                     default: send_word(8'($urandom_range(0, 255)), 1'b0);
                  endcase
               end
               1: send_word(8'($urandom_range(0, 255)), 1'b0);
               default: send_word(8'($urandom_range(8'h20, 8'h7E)), 1'b0);
            endcase
         end
         return;
      end
      if ($urandom_range(0, 2) == 0) send_word(CH_MINUS, 1'b0);
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(11, 22) : $urandom_range(1, 9);
      repeat (len) send_word(CH_ZERO + 8'($urandom_range(0, 9)), 1'b0);
      if (k == COL_DEC && $urandom_range(0, 1)) begin
         send_word(CH_POINT, 1'b0);
         len = ($urandom_range(0, 7) == 0) ? $urandom_range(15, 24) : $urandom_range(0, 5);
         repeat (len) send_word(CH_ZERO + 8'($urandom_range(0, 9)), 1'b0);
      end
   endtask

   task automatic test_random_rows();
      int n, cols, budget;
      while (words_sent < 420) begin
         rx_quiet = ($urandom_range(0, 4) == 0);
         tx_quiet = ($urandom_range(0, 4) == 0);
         set_layout(pick_delim(0), pick_delim(1), 5'($urandom_range(0, 8)), $urandom(),
                    1'($urandom_range(0, 1)), 5'($urandom_range(0, 9)));
         budget = words_sent + $urandom_range(40, 90);
         while (words_sent < budget) begin
            n = eff_count();
            cols = ($urandom_range(0, 5) == 0) ? $urandom_range(1, n) : n;
            if ($urandom_range(0, 7) == 0) begin
               repeat ($urandom_range(1, 6)) send_word(8'($urandom_range(0, 255)), 1'b0);
            end else begin
               for (int c = 0; c < cols; c++) begin
                  send_random_field(kind_at(5'(c)));
                  if (c < cols - 1 || $urandom_range(0, 5) == 0) send_word(fdel, 1'b0);
               end
               if ($urandom_range(0, 9) == 0) send_word(CH_ZERO, 1'b0);
            end
            if ($urandom_range(0, 12) == 0) send_eof();
            else send_word(rdel, 1'b0);
         end
         send_eof();
         drain();
      end
      rx_quiet = 0;
      tx_quiet = 0;
   endtask

   initial begin
      fdel = 8'd58; rdel = 8'd10; ccount = 5'd1; ckinds = '0; eas = 1'b0; acol = 5'd16;
      parser_restart();
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      repeat (2) @(posedge clock);
      test_defaults();
      test_column_types();
      test_register_extremes();
      test_full_queue();
      test_random_rows();
      drain();
      if (pending_results.size() > 0) errors++;
      if (errors == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
